### design/board_piece_list_store_macros.svh
// Assertion macros used by the board store datapath.
// Depends on a clock named clk and a synchronous reset named rst in the including module.
`ifndef BOARD_PIECE_LIST_STORE_MACROS_SVH
`define BOARD_PIECE_LIST_STORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPLS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BPLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bpls_pkg.sv
// Shared types and constants of the board piece-list store.
// No dependencies; used by the controller, the datapath and the top level.
package bpls_pkg;

  localparam int PIECE_W        = 4;
  localparam int SQUARE_W       = 6;
  localparam int SLOT_W         = 4;
  localparam int COUNT_W        = 5;
  localparam int BOARD_SQUARES  = 64;
  localparam int LIST_STRIDE    = 16;
  localparam int SLOTS_PER_TYPE = 16;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OCCUPIED = 2'd1;
  localparam logic [1:0] ERR_EMPTY    = 2'd2;
  localparam logic [1:0] ERR_PIECE    = 2'd3;

  typedef struct packed {
    logic [1:0]          mode;
    logic [PIECE_W-1:0]  piece;
    logic [SQUARE_W-1:0] square;
  } item_t;

  typedef struct packed {
    logic [PIECE_W-1:0]  piece_on_square;
    logic [63:0]         piece_bitboard;
    logic [COUNT_W-1:0]  piece_count;
    logic [1:0]          error;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic move;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic move_needed;
    logic out_free;
  } status_t;

endpackage

### design/bpls_ctrl.sv
// Sequencer of the board piece-list store: idle, execute, move, report.
// Depends on bpls_pkg for the command and status types.
module bpls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bpls_pkg::status_t status,
  output bpls_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_MOVE   = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        // hold the input off while reset is asserted
        item_stall = rst;
        if (item_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.move_needed ? ST_MOVE : ST_REPORT;
      end
      ST_MOVE: begin
        cmd.move   = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/bpls_datapath.sv
// Datapath of the board piece-list store: square map, lists, bitboards, counts, output word.
// Depends on bpls_pkg and board_piece_list_store_macros.svh.
`include "board_piece_list_store_macros.svh"

module bpls_datapath #(
  parameter int PIECE_TYPES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bpls_pkg::item_t   item,
  input  bpls_pkg::cmd_t    cmd,
  output bpls_pkg::status_t status,
  output logic              result_valid,
  input  logic              result_stall,
  output bpls_pkg::result_t result
);

  localparam int TYPE_W     = (PIECE_TYPES > 1) ? $clog2(PIECE_TYPES) : 1;
  localparam int SLOT_W     = bpls_pkg::SLOT_W;
  localparam int LIST_AW    = TYPE_W + SLOT_W;
  localparam int LIST_DEPTH = PIECE_TYPES * bpls_pkg::LIST_STRIDE;
  localparam int PW         = bpls_pkg::PIECE_W;
  localparam int SW         = bpls_pkg::SQUARE_W;
  localparam int CW         = bpls_pkg::COUNT_W;
  localparam int SQUARES    = bpls_pkg::BOARD_SQUARES;

  // item and per-item scratch
  bpls_pkg::item_t item_q;
  logic [PW-1:0]   rem_type;
  logic [SLOT_W-1:0] rem_slot;
  logic [SLOT_W-1:0] rem_last;
  logic [PW-1:0]   pos_q;
  logic [1:0]      err_q;

  // square map: {type, slot}, valid bit per square
  logic [PW+SLOT_W-1:0] map_mem [SQUARES];
  logic [SQUARES-1:0]   map_valid;
  logic [PW+SLOT_W-1:0] map_rdata;
  logic                 map_rvalid;

  // square lists, stride of sixteen per type
  logic [SW-1:0] list_mem [LIST_DEPTH];
  logic [SW-1:0] list_rdata;

  logic [63:0]   bb  [PIECE_TYPES];
  logic [CW-1:0] cnt [PIECE_TYPES];

  logic              is_clear;
  logic              is_add;
  logic              is_remove;
  logic              piece_ok;
  logic [PW-1:0]     entry_type;
  logic [SLOT_W-1:0] entry_slot;
  logic [PW-1:0]     op_type;
  logic [TYPE_W-1:0] rd_idx;
  logic [63:0]       bb_rd;
  logic [CW-1:0]     cnt_rd;
  logic [63:0]       sq_bit;
  logic [SLOT_W-1:0] last_slot;
  logic [1:0]        exec_err;
  logic [PW-1:0]     exec_pos;
  logic              add_ok;
  logic              rem_ok;
  logic              map_we;
  logic [SW-1:0]     map_waddr;
  logic [PW+SLOT_W-1:0] map_wdata;

  assign is_clear   = (item_q.mode == bpls_pkg::MODE_CLEAR);
  assign is_add     = (item_q.mode == bpls_pkg::MODE_ADD);
  assign is_remove  = (item_q.mode == bpls_pkg::MODE_REMOVE);
  assign piece_ok   = (item_q.piece != '0) && (int'(item_q.piece) < PIECE_TYPES);
  assign entry_type = map_rdata[PW+SLOT_W-1:SLOT_W];
  assign entry_slot = map_rdata[SLOT_W-1:0];
  assign op_type    = is_add ? item_q.piece : entry_type;
  // one read port on the type tables: the reported type while reporting
  assign rd_idx     = cmd.report ? item_q.piece[TYPE_W-1:0] : op_type[TYPE_W-1:0];
  assign bb_rd      = bb[rd_idx];
  assign cnt_rd     = cnt[rd_idx];
  assign sq_bit     = 64'(1) << item_q.square;
  assign last_slot  = SLOT_W'(cnt_rd - CW'(1));

  always_comb begin
    exec_err = bpls_pkg::ERR_OK;
    exec_pos = map_rvalid ? entry_type : '0;
    unique case (item_q.mode)
      bpls_pkg::MODE_CLEAR: begin
        exec_pos = '0;
      end
      bpls_pkg::MODE_ADD: begin
        priority if (!piece_ok) begin
          exec_err = bpls_pkg::ERR_PIECE;
        end else if (map_rvalid) begin
          exec_err = bpls_pkg::ERR_OCCUPIED;
        end else if (int'(cnt_rd) >= bpls_pkg::SLOTS_PER_TYPE) begin
          exec_err = bpls_pkg::ERR_PIECE;
        end else begin
          exec_pos = item_q.piece;
        end
      end
      bpls_pkg::MODE_REMOVE: begin
        exec_pos = '0;
        if (!map_rvalid) begin
          exec_err = bpls_pkg::ERR_EMPTY;
        end
      end
      bpls_pkg::MODE_QUERY: begin
        exec_err = bpls_pkg::ERR_OK;
      end
      default: exec_err = bpls_pkg::ERR_OK;
    endcase
  end

  assign add_ok = cmd.exec && is_add && (exec_err == bpls_pkg::ERR_OK);
  assign rem_ok = cmd.exec && is_remove && map_rvalid;

  assign status.move_needed = is_remove && map_rvalid;
  assign status.out_free    = !result_valid || !result_stall;

  // map write port: add writes the new square, move rewrites the moved square
  always_comb begin
    map_we    = 1'b0;
    map_waddr = item_q.square;
    map_wdata = {item_q.piece, cnt_rd[SLOT_W-1:0]};
    if (add_ok) begin
      map_we = 1'b1;
    end else if (cmd.move && (rem_slot != rem_last)) begin
      map_we    = 1'b1;
      map_waddr = list_rdata;
      map_wdata = {rem_type, rem_slot};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q     <= item;
      map_rdata  <= map_mem[item.square];
      map_rvalid <= map_valid[item.square];
    end
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
    end else if (cmd.exec && is_clear) begin
      map_valid <= '0;
    end else if (add_ok) begin
      map_valid[item_q.square] <= 1'b1;
    end else if (rem_ok) begin
      map_valid[item_q.square] <= 1'b0;
    end
  end

  // list memory: add appends, remove reads the last entry, move fills the hole
  always_ff @(posedge clk) begin
    if (add_ok) begin
      list_mem[LIST_AW'({op_type[TYPE_W-1:0], cnt_rd[SLOT_W-1:0]})] <= item_q.square;
    end else if (cmd.move) begin
      list_mem[LIST_AW'({rem_type[TYPE_W-1:0], rem_slot})] <= list_rdata;
    end
    if (rem_ok) begin
      list_rdata <= list_mem[LIST_AW'({op_type[TYPE_W-1:0], last_slot})];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rem_type <= op_type;
      rem_slot <= entry_slot;
      rem_last <= last_slot;
      pos_q    <= exec_pos;
      err_q    <= exec_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIECE_TYPES; i++) begin
        bb[i]  <= '0;
        cnt[i] <= '0;
      end
    end else if (cmd.exec && is_clear) begin
      for (int i = 0; i < PIECE_TYPES; i++) begin
        bb[i]  <= '0;
        cnt[i] <= '0;
      end
    end else if (add_ok) begin
      bb[rd_idx]  <= bb_rd | sq_bit;
      cnt[rd_idx] <= cnt_rd + CW'(1);
    end else if (rem_ok) begin
      bb[rd_idx]  <= bb_rd & ~sq_bit;
      cnt[rd_idx] <= CW'(last_slot);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.report) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      result.piece_on_square <= pos_q;
      result.piece_bitboard  <= piece_ok ? bb_rd : '0;
      result.piece_count     <= piece_ok ? cnt_rd : '0;
      result.error           <= err_q;
    end
  end

  `BPLS_ASSERT_SAME(a_count_matches_board, result_valid, 32'($countones(result.piece_bitboard)) == 32'(result.piece_count), "piece count disagrees with bitboard")
  `BPLS_ASSERT_NEXT(a_add_sets_square, add_ok, map_valid[$past(item_q.square)], "add left square empty")
  `BPLS_ASSERT_NEXT(a_remove_frees_square, rem_ok, !map_valid[$past(item_q.square)], "remove left square occupied")

endmodule

### design/board_piece_list_store.sv
// Board piece-list store. Each word is accepted in idle, reads the square map, updates the
// tables in execute and is loaded into the one output register in report, which waits while
// the output is stalled; a remove that succeeds passes through move in between, since the
// type's last list entry is read through a register. A new word is taken only once the last
// is reported. Reset (rst, synchronous, active high) empties bitboards, counts and map
// entries, stalls the input and idles the sequencer; lists stay.
module board_piece_list_store #(
  parameter int PIECE_TYPES = 16
) (
  input  logic              clk,
  input  logic              rst,
  // input channel: one operation word
  input  logic              item_valid,
  output logic              item_stall,
  input  bpls_pkg::item_t   item,
  // output channel: one result word per operation
  output logic              result_valid,
  input  logic              result_stall,
  output bpls_pkg::result_t result
);

  // Controller and datapath talk only through these two groups.
  bpls_pkg::cmd_t    cmd;
  bpls_pkg::status_t status;

  // Sequencer: idle (accept), execute (check and update), move (swap last list
  // entry into the freed slot, remove only), report (load the output word).
  bpls_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Storage and arithmetic: square map memory with per-square valid bits,
  // list memory, per-type bitboards and counts, and the output register.
  bpls_datapath #(
    .PIECE_TYPES (PIECE_TYPES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### test/tb_board_piece_list_store.sv
// Self-checking bench for board_piece_list_store: random and directed board operations.
// Depends on bpls_pkg and the board_piece_list_store RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_board_piece_list_store;

  localparam int PIECE_TYPES = 16;
  localparam int LONG_HOLD   = 150;   // receiver hold-off, in cycles
  localparam int DRAIN_LIMIT = 5000;  // cycles allowed for outstanding words to drain
  localparam int TAIL_CYCLES = 8;     // settling cycles after the drain, before the last check

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  bpls_pkg::item_t   item         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  bpls_pkg::result_t result;

  // Sender and receiver steering.
  bit quiet    = 1'b0;   // no idling on either side
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off
  int words_sent = 0;

  // Steering shadow of the board, used only to pick useful squares and pieces.
  logic [3:0] gen_type [bpls_pkg::BOARD_SQUARES];
  int         gen_cnt  [PIECE_TYPES];
  int         gen_pop;

  board_piece_list_store #(
    .PIECE_TYPES(PIECE_TYPES)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // Predicts the board after each accepted word and holds the reports still owed.
  class piece_store_tracker;
    logic [63:0]       occ_by_type   [PIECE_TYPES];
    logic [7:0]        slot_map      [bpls_pkg::BOARD_SQUARES];
    logic [5:0]        square_list   [PIECE_TYPES*bpls_pkg::LIST_STRIDE];
    logic [4:0]        count_by_type [PIECE_TYPES];
    bpls_pkg::result_t due_reports   [$];
    int unsigned fails = 0;
    int unsigned checked = 0;
    int unsigned mode_seen [4];
    int unsigned code_seen [4];

    function new();
      foreach (square_list[i]) square_list[i] = '0;
      foreach (mode_seen[i]) mode_seen[i] = 0;
      foreach (code_seen[i]) code_seen[i] = 0;
      wipe_board();
    endfunction

    // Clear leaves the lists alone, just as reset does.
    function void wipe_board();
      foreach (occ_by_type[i]) occ_by_type[i] = '0;
      foreach (slot_map[i]) slot_map[i] = '0;
      foreach (count_by_type[i]) count_by_type[i] = '0;
    endfunction

    function bit piece_valid(logic [3:0] p);
      return (p != 4'd0) && (p < PIECE_TYPES);
    endfunction

    function logic [1:0] place_piece(logic [3:0] p, logic [5:0] sq);
      logic [4:0] n;
      if (!piece_valid(p)) return bpls_pkg::ERR_PIECE;
      // occupancy is looked at only once the piece code is known good
      if (slot_map[sq] != 8'd0) return bpls_pkg::ERR_OCCUPIED;
      n = count_by_type[p];
      if (n >= bpls_pkg::SLOTS_PER_TYPE || n >= bpls_pkg::LIST_STRIDE)
        return bpls_pkg::ERR_PIECE;
      occ_by_type[p][sq]        = 1'b1;
      slot_map[sq]              = {p, n[3:0]};
      square_list[{p, n[3:0]}]  = sq;
      count_by_type[p]          = n + 5'd1;
      return bpls_pkg::ERR_OK;
    endfunction

    function logic [1:0] lift_piece(logic [5:0] sq);
      logic [7:0] entry;
      logic [3:0] p;
      logic [3:0] slot;
      logic [3:0] last;
      logic [5:0] moved;
      entry = slot_map[sq];
      if (entry == 8'd0) return bpls_pkg::ERR_EMPTY;
      p    = entry[7:4];
      slot = entry[3:0];
      last = count_by_type[p][3:0] - 4'd1;
      occ_by_type[p][sq] = 1'b0;
      // swap the last list entry into the freed slot and repoint its map entry
      moved = square_list[{p, last}];
      square_list[{p, slot}] = moved;
      if (slot != last) slot_map[moved] = {p, slot};
      slot_map[sq]     = 8'd0;
      count_by_type[p] = {1'b0, last};
      return bpls_pkg::ERR_OK;
    endfunction

    function void note_operation(bpls_pkg::item_t w);
      bpls_pkg::result_t want;
      logic [1:0]        code;
      code = bpls_pkg::ERR_OK;
      case (w.mode)
        bpls_pkg::MODE_CLEAR:  wipe_board();
        bpls_pkg::MODE_ADD:    code = place_piece(w.piece, w.square);
        bpls_pkg::MODE_REMOVE: code = lift_piece(w.square);
        bpls_pkg::MODE_QUERY:  ;
        default:               ;
      endcase
      want.piece_on_square = slot_map[w.square][7:4];
      want.piece_bitboard  = piece_valid(w.piece) ? occ_by_type[w.piece] : 64'd0;
      want.piece_count     = piece_valid(w.piece) ? count_by_type[w.piece] : 5'd0;
      want.error           = code;
      due_reports.push_back(want);
      mode_seen[w.mode]++;
      code_seen[code]++;
    endfunction

    task report(string msg);
      fails++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_report(bpls_pkg::result_t got);
      bpls_pkg::result_t want;
      if (due_reports.size() == 0) begin
        report("result word arrived with nothing owed");
        return;
      end
      want = due_reports.pop_front();
      if (got.piece_on_square !== want.piece_on_square)
        report($sformatf("word %0d piece_on_square %0d, want %0d",
                         checked, got.piece_on_square, want.piece_on_square));
      if (got.piece_bitboard !== want.piece_bitboard)
        report($sformatf("word %0d piece_bitboard %h, want %h",
                         checked, got.piece_bitboard, want.piece_bitboard));
      if (got.piece_count !== want.piece_count)
        report($sformatf("word %0d piece_count %0d, want %0d",
                         checked, got.piece_count, want.piece_count));
      if (got.error !== want.error)
        report($sformatf("word %0d error %0d, want %0d", checked, got.error, want.error));
      checked++;
    endtask

    function int pending();
      return due_reports.size();
    endfunction
  endclass

  piece_store_tracker tracker;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels on the edge; all drive is nonblocking, so these
  // reads see the values that the block saw.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) tracker.note_operation(item);
    if (!rst && result_valid && !result_stall) tracker.check_report(result);
  end

  // Receiver: short random stalls, one long hold-off on request, none when quiet.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Track the board loosely so that removes mostly hit occupied squares
  // and adds mostly hit empty ones.
  function void shadow_apply(bpls_pkg::item_t w);
    case (w.mode)
      bpls_pkg::MODE_CLEAR: begin
        foreach (gen_type[i]) gen_type[i] = 4'd0;
        foreach (gen_cnt[i]) gen_cnt[i] = 0;
        gen_pop = 0;
      end
      bpls_pkg::MODE_ADD: begin
        if (w.piece != 4'd0 && w.piece < PIECE_TYPES && gen_type[w.square] == 4'd0 &&
            gen_cnt[w.piece] < bpls_pkg::SLOTS_PER_TYPE) begin
          gen_type[w.square] = w.piece;
          gen_cnt[w.piece]++;
          gen_pop++;
        end
      end
      bpls_pkg::MODE_REMOVE: begin
        if (gen_type[w.square] != 4'd0) begin
          gen_cnt[gen_type[w.square]]--;
          gen_type[w.square] = 4'd0;
          gen_pop--;
        end
      end
      default: ;
    endcase
  endfunction

  // Scan from a random start for a square that is (or is not) occupied.
  function int pick_square(bit want_occupied);
    int start;
    int idx;
    start = $urandom_range(0, bpls_pkg::BOARD_SQUARES - 1);
    for (int i = 0; i < bpls_pkg::BOARD_SQUARES; i++) begin
      idx = (start + i) % bpls_pkg::BOARD_SQUARES;
      if ((gen_type[idx] != 4'd0) == want_occupied) return idx;
    end
    return start;
  endfunction

  function bpls_pkg::item_t make_op(logic [1:0] mode, int piece, int square);
    bpls_pkg::item_t w;
    w.mode   = mode;
    w.piece  = 4'(piece);
    w.square = 6'(square);
    return w;
  endfunction

  // Mostly legal adds and removes with random content; the rest is noise.
  function bpls_pkg::item_t random_word();
    bpls_pkg::item_t w;
    int              r;
    int              add_band;
    int              sq;
    r        = $urandom_range(0, 99);
    add_band = (gen_pop > 40) ? 35 : 60;
    if (r < 2) begin
      w = make_op(bpls_pkg::MODE_CLEAR, $urandom_range(0, 15), $urandom_range(0, 63));
    end else if (r < 8) begin
      w = make_op(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 63));
    end else if (r < 16) begin
      w = make_op(bpls_pkg::MODE_QUERY, $urandom_range(0, 15), $urandom_range(0, 63));
    end else if (r < add_band) begin
      w = make_op(bpls_pkg::MODE_ADD, $urandom_range(1, 15), pick_square(1'b0));
    end else begin
      sq = pick_square(1'b1);
      w  = make_op(bpls_pkg::MODE_REMOVE,
                   $urandom_range(0, 1) ? int'(gen_type[sq]) : $urandom_range(0, 15), sq);
    end
    return w;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input bpls_pkg::item_t w);
    shadow_apply(w);
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [1:0] mode, input int piece, input int square);
    send_word(make_op(mode, piece, square));
    maybe_idle();
  endtask

  task automatic random_run(input int n);
    repeat (n) begin
      send_word(random_word());
      maybe_idle();
    end
  endtask

  // Fill one type's list to the top, overflow it once, then shrink it again.
  task automatic fill_type(input int t);
    send_op(bpls_pkg::MODE_CLEAR, t, $urandom_range(0, 63));
    repeat (bpls_pkg::SLOTS_PER_TYPE + 1) send_op(bpls_pkg::MODE_ADD, t, pick_square(1'b0));
    repeat (8) send_op(bpls_pkg::MODE_REMOVE, t, pick_square(1'b1));
  endtask

  // Stop offering and wait for every owed report, with a bound.
  task automatic wait_drained();
    int guard;
    guard = 0;
    item_valid <= 1'b0;
    while (tracker.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    tracker = new();
    foreach (gen_type[i]) gen_type[i] = 4'd0;
    foreach (gen_cnt[i]) gen_cnt[i] = 0;
    gen_pop = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset state, bad piece, occupied square, empty remove,
    // list swaps on remove, out-of-range reporting, clear.
    send_op(bpls_pkg::MODE_QUERY,  1,  0);
    send_op(bpls_pkg::MODE_ADD,    0,  5);
    send_op(bpls_pkg::MODE_ADD,    15, 63);
    send_op(bpls_pkg::MODE_ADD,    1,  0);
    send_op(bpls_pkg::MODE_ADD,    2,  0);
    send_op(bpls_pkg::MODE_ADD,    0,  0);
    send_op(bpls_pkg::MODE_REMOVE, 4,  5);
    send_op(bpls_pkg::MODE_ADD,    2,  10);
    send_op(bpls_pkg::MODE_ADD,    2,  20);
    send_op(bpls_pkg::MODE_ADD,    2,  30);
    send_op(bpls_pkg::MODE_REMOVE, 2,  10);
    send_op(bpls_pkg::MODE_REMOVE, 2,  30);
    send_op(bpls_pkg::MODE_QUERY,  2,  20);
    send_op(bpls_pkg::MODE_REMOVE, 2,  20);
    send_op(bpls_pkg::MODE_QUERY,  0,  63);
    send_op(bpls_pkg::MODE_QUERY,  15, 63);
    send_op(bpls_pkg::MODE_REMOVE, 9,  0);
    send_op(bpls_pkg::MODE_CLEAR,  15, 0);
    send_op(bpls_pkg::MODE_QUERY,  15, 63);
    send_op(bpls_pkg::MODE_ADD,    15, 0);

    // Full-list overflow, first on a random type.
    fill_type($urandom_range(1, 15));
    random_run(280);

    // Hold the receiver off while words keep coming, so the block backs up.
    hold_req = 1'b1;
    random_run(40);

    // Pause the sender until every report is in.
    wait_drained();

    fill_type(15);
    random_run(230);

    // Last stretch runs at full rate on both sides.
    quiet = 1'b1;
    random_run(100);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d reports never arrived", tracker.pending()));

    $display("covered %0d words: %0d clears, %0d adds, %0d removes, %0d queries",
             words_sent, tracker.mode_seen[bpls_pkg::MODE_CLEAR],
             tracker.mode_seen[bpls_pkg::MODE_ADD],
             tracker.mode_seen[bpls_pkg::MODE_REMOVE],
             tracker.mode_seen[bpls_pkg::MODE_QUERY]);
    $display("outcomes: %0d ok, %0d occupied, %0d empty, %0d bad piece or full; %0d checked",
             tracker.code_seen[bpls_pkg::ERR_OK], tracker.code_seen[bpls_pkg::ERR_OCCUPIED],
             tracker.code_seen[bpls_pkg::ERR_EMPTY], tracker.code_seen[bpls_pkg::ERR_PIECE],
             tracker.checked);
    if (tracker.fails == 0) begin
      $display("tb_board_piece_list_store: PASS");
    end else begin
      $display("tb_board_piece_list_store: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb_board_piece_list_store: FAIL");
    $finish;
  end

endmodule
